// File: hw/rtl/assert_macros.svh
// Assertion macros used by the smoothing filter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ssf_pkg.sv
// Package of the smoothing filter: widths, register indexes, mode codes, helpers.
`default_nettype none
package ssf_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int WEIGHT_W    = 18;
  localparam int ALPHA_W     = 17;
  localparam int PROD_W      = WEIGHT_W + SAMPLE_W;      // tap product, Q.32
  localparam int RND_W       = PROD_W - 16;              // rounded tap product
  localparam int SUM_W       = RND_W + 3;                // sum of up to six taps
  localparam int XSUM_W      = SAMPLE_W + 1;             // x + x_prev
  localparam int FF_W        = ALPHA_W + 1 + XSUM_W;     // a * (x + x_prev)
  localparam int FB_W        = ALPHA_W + 1 + SAMPLE_W;   // (1 - a) * y_prev
  localparam int NUM_W       = FF_W + 1;                 // low-pass numerator
  localparam int LP_W        = NUM_W - 17;               // low-pass after shift
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_ALPHA = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_WEIGHT_0    = 3'd2;

  localparam logic [1:0] MODE_PASS     = 2'd0;
  localparam logic [1:0] MODE_LOW_PASS = 2'd1;
  localparam logic [1:0] MODE_FIR      = 2'd2;

  typedef struct packed {
    logic load;     // a word is accepted: take the tap sample and multiply
    logic advance;  // the first stage moves on: round the product
  } cell_ctrl_t;

  // Clamp a wide signed value to the 32-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if ((&v[SUM_W-1:SAMPLE_W-1]) || !(|v[SUM_W-1:SAMPLE_W-1])) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sample_series_smoothing_filter_core.sv
// Smoothing filter core: a chain of FIR tap cells plus the low-pass recurrence.
//
// Samples (signed Q16.16) enter on the in channel (in_valid, in_ready) with
// series_start marking the first word of a new series; each word gives exactly
// one filtered word on the out channel (out_valid, out_ready), in order.
// filter_mode selects pass-through, first-order low-pass or FIR; the user must
// write the registers through cfg_we, cfg_index and cfg_data only while no word
// is in flight, which the block does not enforce. The three register stages:
// the tap multiply loads at acceptance, the product rounding when the word
// advances, then the tap sum with the low-pass feedback and saturation, which
// loads the output register. One word is accepted every cycle while the
// pipeline has room; the low-pass loop closes through the single feedback
// multiplier of the last stage. The history shifts along the tap cells, one
// sample per accepted word. When the receiver stalls, each stage holds its word
// and the block keeps taking input until all three are full; in_ready then falls.
// Reset empties the pipeline, clears the history and the previous output and
// returns the registers to pass-through, alpha one and a unit first tap.
`default_nettype none
`include "assert_macros.svh"
module sample_series_smoothing_filter_core #(
  parameter int TAP_COUNT = 6
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [ssf_pkg::SAMPLE_W-1:0]    sample_in,
  input  wire logic                                   series_start,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [ssf_pkg::SAMPLE_W-1:0]         sample_out,
  input  wire logic                                   cfg_we,
  input  wire logic [ssf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [ssf_pkg::CFG_DATA_W-1:0]         cfg_data
);

  logic [1:0]                                 filter_mode;
  logic [ssf_pkg::ALPHA_W-1:0]                smoothing_alpha;
  logic signed [ssf_pkg::WEIGHT_W-1:0]        tap_weight [TAP_COUNT];

  logic                                       in_accept;
  logic                                       s2_load;
  logic                                       out_load;
  logic                                       s1_valid;
  logic                                       s2_valid;

  ssf_pkg::cell_ctrl_t                        cell_ctrl;
  logic signed [ssf_pkg::SAMPLE_W-1:0]        tap_in  [TAP_COUNT];
  logic signed [ssf_pkg::SAMPLE_W-1:0]        hist    [TAP_COUNT];
  logic signed [ssf_pkg::RND_W-1:0]           rounded [TAP_COUNT];

  logic signed [ssf_pkg::SAMPLE_W-1:0]        x1;
  logic                                       start1;
  logic signed [ssf_pkg::XSUM_W-1:0]          xsum1;
  logic signed [ssf_pkg::SAMPLE_W-1:0]        x2;
  logic                                       start2;
  logic signed [ssf_pkg::FF_W-1:0]            ff2;
  logic signed [ssf_pkg::SAMPLE_W-1:0]        past_output;

  logic signed [ssf_pkg::SAMPLE_W-1:0]        x_prev;
  logic [ssf_pkg::ALPHA_W-1:0]                alpha_eff;
  logic [ssf_pkg::ALPHA_W-1:0]                alpha_rest;
  logic signed [ssf_pkg::SAMPLE_W-1:0]        y_prev;
  logic signed [ssf_pkg::FB_W-1:0]            fb;
  logic signed [ssf_pkg::NUM_W-1:0]           num_biased;
  logic signed [ssf_pkg::LP_W-1:0]            lp;
  logic signed [ssf_pkg::SUM_W-1:0]           fir_sum;
  logic signed [ssf_pkg::SAMPLE_W-1:0]        sample_out_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode     <= ssf_pkg::MODE_PASS;
      smoothing_alpha <= ssf_pkg::ALPHA_ONE;
      for (int t = 0; t < TAP_COUNT; t++) begin
        tap_weight[t] <= (t == 0) ? ssf_pkg::WEIGHT_W'(65536) : '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssf_pkg::REG_FILTER_MODE:     filter_mode     <= cfg_data[1:0];
        ssf_pkg::REG_SMOOTHING_ALPHA: smoothing_alpha <= cfg_data[ssf_pkg::ALPHA_W-1:0];
        default: begin
          // Taps beyond TAP_COUNT have no storage and their writes are dropped.
          for (int t = 0; t < TAP_COUNT; t++) begin
            if (cfg_index == ssf_pkg::REG_TAP_WEIGHT_0 + ssf_pkg::CFG_INDEX_W'(t)) begin
              tap_weight[t] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  // Pipeline handshake: each stage moves on when the one after it has room.
  assign out_load  = s2_valid && (!out_valid || out_ready);
  assign s2_load   = s1_valid && (!s2_valid || out_load);
  assign in_ready  = !s1_valid || s2_load;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_accept || (s1_valid && !s2_load);
      s2_valid  <= s2_load || (s2_valid && !out_load);
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  // Tap cells. A new series sees zero history beyond the current sample.
  assign cell_ctrl.load    = in_accept;
  assign cell_ctrl.advance = s2_load;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
    if (k == 0) begin : g_first
      assign tap_in[k] = sample_in;
    end else begin : g_rest
      assign tap_in[k] = series_start ? '0 : hist[k-1];
    end

    ssf_tap_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cell_ctrl),
      .tap_in  (tap_in[k]),
      .weight  (tap_weight[k]),
      .hist    (hist[k]),
      .rounded (rounded[k])
    );
  end

  // Low-pass feed-forward term, built over the first two stages.
  assign x_prev     = series_start ? sample_in : hist[0];
  assign alpha_eff  = (smoothing_alpha > ssf_pkg::ALPHA_ONE) ? ssf_pkg::ALPHA_ONE
                                                             : smoothing_alpha;
  assign alpha_rest = ssf_pkg::ALPHA_ONE - alpha_eff;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x1     <= sample_in;
      start1 <= series_start;
      xsum1  <= ssf_pkg::XSUM_W'(sample_in) + ssf_pkg::XSUM_W'(x_prev);
    end
    if (s2_load) begin
      x2     <= x1;
      start2 <= start1;
      ff2    <= $signed({1'b0, alpha_eff}) * xsum1;
    end
  end

  // Last stage: feedback multiply, tap sum, rounding and saturation.
  assign y_prev     = start2 ? x2 : past_output;
  assign fb         = $signed({1'b0, alpha_rest}) * y_prev;
  assign num_biased = ssf_pkg::NUM_W'(ff2) + (ssf_pkg::NUM_W'(fb) <<< 1)
                      + (ssf_pkg::NUM_W'(1) << 16);
  assign lp         = num_biased[ssf_pkg::NUM_W-1:17];

  always_comb begin
    fir_sum = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      fir_sum = fir_sum + ssf_pkg::SUM_W'(rounded[k]);
    end
  end

  always_comb begin
    case (filter_mode)
      ssf_pkg::MODE_LOW_PASS: sample_out_next = ssf_pkg::sat32(ssf_pkg::SUM_W'(lp));
      ssf_pkg::MODE_FIR:      sample_out_next = ssf_pkg::sat32(fir_sum);
      default:                sample_out_next = x2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      past_output <= '0;
    end else if (out_load) begin
      past_output <= sample_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= sample_out_next;
    end
  end

  `ASSERT_CLK(a_hist_capture, in_accept |=> hist[0] == $past(sample_in), "history missed sample")
  `ASSERT_CLK(a_feedback_track, out_load |=> past_output == sample_out, "feedback lost output")
  `ASSERT_ALWAYS(a_ready_full, !in_ready |-> (s1_valid && s2_valid && out_valid), "stall early")

endmodule
`default_nettype wire

// File: hw/rtl/ssf_tap_cell.sv
// One FIR tap: holds one history sample, multiplies and rounds its product.
`default_nettype none
module ssf_tap_cell (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire ssf_pkg::cell_ctrl_t                     ctrl,
  input  wire logic signed [ssf_pkg::SAMPLE_W-1:0]     tap_in,
  input  wire logic signed [ssf_pkg::WEIGHT_W-1:0]     weight,
  output logic signed [ssf_pkg::SAMPLE_W-1:0]          hist,
  output logic signed [ssf_pkg::RND_W-1:0]             rounded
);

  localparam logic signed [ssf_pkg::PROD_W-1:0] HALF_LSB = ssf_pkg::PROD_W'(1) << 15;

  logic signed [ssf_pkg::PROD_W-1:0] product;
  logic signed [ssf_pkg::PROD_W-1:0] biased;

  // The held sample is what the next cell sees as its tap sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctrl.load) begin
      hist <= tap_in;
    end
  end

  assign biased = product + HALF_LSB;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      product <= weight * tap_in;
    end
    if (ctrl.advance) begin
      rounded <= biased[ssf_pkg::PROD_W-1:16];
    end
  end

endmodule
`default_nettype wire

// File: verif/sample_series_smoothing_filter_core_tb.sv
// Self-checking testbench of the sample series smoothing filter core.
`timescale 1ns / 1ps
module sample_series_smoothing_filter_core_tb;

  localparam int TAP_COUNT        = 6;
  localparam int HIST_DEPTH       = 5;
  localparam int FRAC_BITS        = 16;
  localparam int LP_SHIFT         = 17;
  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 9;
  localparam int PIPE_LATENCY     = 3;
  localparam int SETTLE_CYCLES    = PIPE_LATENCY + 5;
  localparam int MAX_GAP          = 12;
  localparam int SINK_HOLD_CYCLES = 80;
  localparam int RANDOM_WORDS     = 850;
  localparam int MAX_REPORTS      = 100;
  localparam int DIR_ROWS         = 30;
  localparam int TIMEOUT_NS       = 2_000_000;
  localparam int EXPECT_DEPTH     = 64;

  localparam logic [1:0] MODE_UNDEFINED = 2'd3;

  typedef logic signed [ssf_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic signed [ssf_pkg::WEIGHT_W-1:0] weight_t;
  typedef logic [ssf_pkg::CFG_INDEX_W-1:0]     reg_index_t;
  typedef logic [ssf_pkg::CFG_DATA_W-1:0]      reg_data_t;

  localparam sample_t   SAMPLE_MAX  = 32'sh7FFF_FFFF;
  localparam sample_t   SAMPLE_MIN  = 32'sh8000_0000;
  localparam reg_data_t WEIGHT_MAX  = 18'h1FFFF;
  localparam reg_data_t WEIGHT_MIN  = 18'h20000;
  localparam reg_data_t ALPHA_ABOVE = 18'h1FFFF;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    reg_index_t reg_idx;
    reg_data_t  reg_val;
    sample_t    sample;
    logic       first;
    logic       typed;
    sample_t    want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  sample_t    sample_in;
  logic       series_start;
  logic       out_valid;
  logic       out_ready;
  sample_t    sample_out;
  logic       cfg_we;
  reg_index_t cfg_index;
  reg_data_t  cfg_data;

  // Filter settings and history as the testbench believes them to be.
  logic [1:0]                  filt_mode;
  logic [ssf_pkg::ALPHA_W-1:0] lp_alpha;
  weight_t                     tap_coef [TAP_COUNT];
  sample_t                     past_x [HIST_DEPTH];
  sample_t                     past_y;

  // Expected words waiting for the receiver, kept as a ring.
  sample_t   expect_buf [EXPECT_DEPTH];
  int        expect_wr;
  int        expect_rd;
  stim_row_t dir_rows [DIR_ROWS];
  int        mismatch_count;
  int        src_gap_max;
  int        sink_gap_max;
  int        sink_wait;
  bit        sink_hold_req;

  sample_series_smoothing_filter_core #(
    .TAP_COUNT(TAP_COUNT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .series_start(series_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic sample_t clamp_sample(longint v);
    if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return sample_t'(v);
  endfunction

  // Round to nearest with ties towards plus infinity, then drop sh bits.
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic void reset_filter_state();
    filt_mode = ssf_pkg::MODE_PASS;
    lp_alpha  = ssf_pkg::ALPHA_ONE;
    for (int k = 0; k < TAP_COUNT; k++) tap_coef[k] = '0;
    tap_coef[0] = weight_t'(ssf_pkg::ALPHA_ONE);
    for (int i = 0; i < HIST_DEPTH; i++) past_x[i] = '0;
    past_y = '0;
  endfunction

  function automatic void apply_register(reg_index_t idx, reg_data_t val);
    if (idx == ssf_pkg::REG_FILTER_MODE) begin
      filt_mode = val[1:0];
    end else if (idx == ssf_pkg::REG_SMOOTHING_ALPHA) begin
      lp_alpha = val[ssf_pkg::ALPHA_W-1:0];
    end else begin
      tap_coef[idx - ssf_pkg::REG_TAP_WEIGHT_0] = weight_t'(val);
    end
  endfunction

  function automatic sample_t smooth_predict(sample_t x, logic first);
    longint  a;
    longint  x_prev;
    longint  y_prev;
    longint  num;
    longint  acc;
    longint  tap_in;
    sample_t y;
    if (first) begin
      for (int i = 0; i < HIST_DEPTH; i++) past_x[i] = '0;
    end
    case (filt_mode)
      ssf_pkg::MODE_LOW_PASS: begin
        a = (lp_alpha > ssf_pkg::ALPHA_ONE) ? longint'(ssf_pkg::ALPHA_ONE)
                                            : longint'(lp_alpha);
        // A new series takes its first sample as both previous input and output.
        x_prev = first ? longint'(x) : longint'(past_x[0]);
        y_prev = first ? longint'(x) : longint'(past_y);
        num = (longint'(ssf_pkg::ALPHA_ONE) - a) * 2 * y_prev
              + a * (longint'(x) + x_prev);
        y = clamp_sample(round_shift(num, LP_SHIFT));
      end
      ssf_pkg::MODE_FIR: begin
        acc = 0;
        for (int k = 0; k < TAP_COUNT; k++) begin
          tap_in = (k == 0) ? longint'(x) : longint'(past_x[k - 1]);
          acc += round_shift(longint'(tap_coef[k]) * tap_in, FRAC_BITS);
        end
        y = clamp_sample(acc);
      end
      default: y = x;
    endcase
    for (int i = HIST_DEPTH - 1; i > 0; i--) past_x[i] = past_x[i - 1];
    past_x[0] = x;
    past_y = y;
    return y;
  endfunction

  function automatic reg_index_t tap_reg(int k);
    return reg_index_t'(ssf_pkg::REG_TAP_WEIGHT_0 + k);
  endfunction

  function automatic stim_row_t reg_row(reg_index_t idx, reg_data_t val);
    return '{ROW_REG, idx, val, '0, 1'b0, 1'b0, '0};
  endfunction

  function automatic stim_row_t word_row(sample_t x, logic first);
    return '{ROW_WORD, '0, '0, x, first, 1'b0, '0};
  endfunction

  function automatic stim_row_t word_known(sample_t x, logic first, sample_t want);
    return '{ROW_WORD, '0, '0, x, first, 1'b1, want};
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'($urandom_range(32'h0004_0000));
      3: return -sample_t'($urandom_range(32'h0004_0000));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic reg_data_t random_weight();
    case ($urandom_range(5))
      0: return WEIGHT_MAX;
      1: return WEIGHT_MIN;
      2: return '0;
      3: return reg_data_t'($urandom_range(98304, 32768));
      4: return reg_data_t'(-$signed($urandom_range(98304, 32768)));
      default: return reg_data_t'($urandom);
    endcase
  endfunction

  function automatic reg_data_t random_alpha();
    case ($urandom_range(4))
      0: return '0;
      1: return reg_data_t'(ssf_pkg::ALPHA_ONE);
      2: return reg_data_t'($urandom_range(131071, 65537));
      default: return reg_data_t'($urandom_range(65536));
    endcase
  endfunction

  function automatic reg_data_t random_mode();
    case ($urandom_range(9))
      0: return reg_data_t'(ssf_pkg::MODE_PASS);
      1: return reg_data_t'(MODE_UNDEFINED);
      2, 3, 4, 5: return reg_data_t'(ssf_pkg::MODE_LOW_PASS);
      default: return reg_data_t'(ssf_pkg::MODE_FIR);
    endcase
  endfunction

  function automatic int expect_count();
    return expect_wr - expect_rd;
  endfunction

  function automatic void expect_store(sample_t v);
    expect_buf[expect_wr % EXPECT_DEPTH] = v;
    expect_wr++;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_word(sample_t got);
    sample_t want;
    if (expect_count() == 0) begin
      report_mismatch($sformatf("output word %h with no word outstanding", got));
    end else begin
      want = expect_buf[expect_rd % EXPECT_DEPTH];
      expect_rd++;
      if (got !== want) begin
        report_mismatch($sformatf("sample_out %h, expected %h", got, want));
      end
    end
  endtask

  // Called at a falling edge; leaves cfg_we high for the caller to close.
  task automatic reg_write(reg_index_t idx, reg_data_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_register(idx, val);
    @(negedge clk);
  endtask

  task automatic send_word(sample_t x, logic first, logic typed, sample_t want);
    int      gap;
    sample_t predicted;
    gap = $urandom_range(src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_in    <= x;
    series_start <= first;
    do @(posedge clk); while (!in_ready);
    predicted = smooth_predict(x, first);
    expect_store(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Waits until every outstanding word has come out and the pipeline is quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expect_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls after each word, plus a long hold when asked for.
  initial begin
    int got_count;
    got_count    = 0;
    out_ready    = 1'b0;
    sink_wait    = 0;
    sink_gap_max = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        check_word(sample_out);
        got_count++;
        if (got_count % 40 == 0) begin
          sink_gap_max = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_GAP, 1);
        end
        sink_wait = $urandom_range(sink_gap_max);
      end
      @(negedge clk);
      if (sink_hold_req) begin
        sink_wait     = SINK_HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
      if (sink_wait > 0) begin
        out_ready <= 1'b0;
        sink_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t row;
    int        sent;
    int        phase;
    int        phase_len;
    bit        reg_open;
    logic      first;
    rst            = 1'b1;
    in_valid       = 1'b0;
    sample_in      = '0;
    series_start   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_gap_max    = 3;
    sink_hold_req  = 1'b0;
    mismatch_count = 0;
    expect_wr      = 0;
    expect_rd      = 0;
    reset_filter_state();

    // The first FIR word runs before any series start, so it sees the reset
    // zeros in the history whatever the later taps hold.
    dir_rows = '{
      reg_row(tap_reg(1), WEIGHT_MAX),
      reg_row(tap_reg(5), WEIGHT_MIN),
      reg_row(ssf_pkg::REG_FILTER_MODE, reg_data_t'(ssf_pkg::MODE_FIR)),
      word_known(32'sh0003_0000, 1'b0, 32'sh0003_0000),
      word_row(-32'sh0001_0000, 1'b0),
      word_row(SAMPLE_MAX, 1'b0),
      reg_row(tap_reg(0), WEIGHT_MAX),
      word_known(SAMPLE_MAX, 1'b1, SAMPLE_MAX),
      word_known(SAMPLE_MIN, 1'b1, SAMPLE_MIN),
      reg_row(tap_reg(0), WEIGHT_MIN),
      word_known(SAMPLE_MIN, 1'b1, SAMPLE_MAX),
      word_row(32'sh1234_5678, 1'b0),
      word_row(-32'sd1, 1'b0),
      reg_row(ssf_pkg::REG_FILTER_MODE, reg_data_t'(ssf_pkg::MODE_LOW_PASS)),
      reg_row(ssf_pkg::REG_SMOOTHING_ALPHA, ALPHA_ABOVE),
      word_known(32'sd5, 1'b1, 32'sd5),
      word_row(SAMPLE_MAX, 1'b0),
      word_row(SAMPLE_MIN, 1'b0),
      reg_row(ssf_pkg::REG_SMOOTHING_ALPHA, '0),
      word_known(32'sd77, 1'b1, 32'sd77),
      word_known(32'sd1000, 1'b0, 32'sd77),
      word_known(SAMPLE_MAX, 1'b0, 32'sd77),
      word_known(SAMPLE_MIN, 1'b1, SAMPLE_MIN),
      reg_row(ssf_pkg::REG_SMOOTHING_ALPHA, reg_data_t'(ssf_pkg::ALPHA_ONE)),
      word_row(32'sh0000_8000, 1'b0),
      reg_row(ssf_pkg::REG_FILTER_MODE, reg_data_t'(MODE_UNDEFINED)),
      word_known(-32'sd7, 1'b0, -32'sd7),
      reg_row(ssf_pkg::REG_FILTER_MODE, reg_data_t'(ssf_pkg::MODE_PASS)),
      word_known(32'sd0, 1'b1, 32'sd0),
      word_known(SAMPLE_MIN, 1'b0, SAMPLE_MIN)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    reg_open = 1'b0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        if (!reg_open) begin
          drain_block();
          reg_open = 1'b1;
        end
        reg_write(row.reg_idx, row.reg_val);
      end else begin
        if (reg_open) begin
          cfg_we  <= 1'b0;
          reg_open = 1'b0;
        end
        send_word(row.sample, row.first, row.typed, row.want);
      end
    end

    // Random phases: new settings while idle, then a batch of series.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      drain_block();
      reg_write(ssf_pkg::REG_FILTER_MODE, random_mode());
      if (phase == 0 || $urandom_range(3) != 0) begin
        reg_write(ssf_pkg::REG_SMOOTHING_ALPHA, random_alpha());
      end
      for (int k = 0; k < TAP_COUNT; k++) begin
        if (phase == 0 || $urandom_range(3) != 0) reg_write(tap_reg(k), random_weight());
      end
      cfg_we <= 1'b0;
      case ($urandom_range(2))
        0: src_gap_max = 0;
        1: src_gap_max = 3;
        default: src_gap_max = MAX_GAP;
      endcase
      // Back-to-back words against a long receiver hold fill the pipeline.
      if (phase == 2 || phase == 6) begin
        src_gap_max   = 0;
        sink_hold_req = 1'b1;
      end
      phase_len = $urandom_range(90, 30);
      for (int n = 0; n < phase_len; n++) begin
        first = (n == 0) ? ($urandom_range(1) == 1) : ($urandom_range(9) == 0);
        send_word(random_sample(), first, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
